// ----- rtl/core/ray_box_slab_intersect_assert.svh -----
// Assertion macros for the ray/box slab intersection block
`ifndef RAY_BOX_SLAB_INTERSECT_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_ASSERT_SVH

// same-cycle implication
`define RBSI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rbsi assertion failed");

// next-cycle implication
`define RBSI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rbsi assertion failed");

`endif

// ----- rtl/core/rbsi_pkg.sv -----
// Shared types and constants for the ray/box slab intersection block
package rbsi_pkg;

  localparam int COORD_W = 32;
  localparam int DIST_W  = 31;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

  localparam logic [COORD_W-1:0] BOX_MIN_RST = 32'd0;
  localparam logic [COORD_W-1:0] BOX_MAX_RST = 32'd65536;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // per-item data carried alongside the dividers
  typedef struct packed {
    logic [2:0][COORD_W-1:0] o;
    logic [2:0][COORD_W-1:0] d;
    logic [2:0]              neg_min;
    logic [2:0]              neg_max;
    logic [2:0]              dzero;
    logic                    miss;
  } sb_t;

endpackage

// ----- rtl/core/rbsi_div.sv -----
// Pipelined restoring divider, one quotient bit per stage
module rbsi_div #(
  parameter int NUM_W  = 33,
  parameter int FRAC_W = 16
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [NUM_W-1:0]                num,
  input  logic [rbsi_pkg::COORD_W-1:0]    den,
  output logic [NUM_W+FRAC_W-1:0]         quo
);

  localparam int Q_W = NUM_W + FRAC_W;
  localparam int D_W = rbsi_pkg::COORD_W;

  logic [Q_W-1:0] dvd_r [Q_W];
  logic [Q_W-1:0] quo_r [Q_W];
  logic [D_W-1:0] rem_r [Q_W];
  logic [D_W-1:0] den_r [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [Q_W-1:0] dvd_p;
    logic [Q_W-1:0] quo_p;
    logic [D_W-1:0] rem_p;
    logic [D_W-1:0] den_p;
    logic [D_W:0]   trial;
    logic [D_W:0]   diff;
    logic           ge;

    if (j == 0) begin : g_first
      assign dvd_p = {num, {FRAC_W{1'b0}}};
      assign quo_p = '0;
      assign rem_p = '0;
      assign den_p = den;
    end else begin : g_next
      assign dvd_p = dvd_r[j-1];
      assign quo_p = quo_r[j-1];
      assign rem_p = rem_r[j-1];
      assign den_p = den_r[j-1];
    end

    assign trial = {rem_p, dvd_p[Q_W-1]};
    assign ge    = trial >= {1'b0, den_p};
    assign diff  = trial - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (en) begin
        dvd_r[j] <= {dvd_p[Q_W-2:0], 1'b0};
        quo_r[j] <= {quo_p[Q_W-2:0], ge};
        rem_r[j] <= ge ? diff[D_W-1:0] : trial[D_W-1:0];
        den_r[j] <= den_p;
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

// ----- rtl/core/ray_box_slab_intersect.sv -----
// Ray versus axis-aligned box intersection, slab method, fully pipelined
//
//  channel | direction | handshake        | payload
//  in_     | input     | in_valid/ready   | origin_x/y/z, dir_x/y/z
//  out_    | output    | out_valid/ready  | hit, distance, face_axis, normal_negative,
//          |           |                  | face_u, face_v
//  cfg_    | input     | cfg_we           | cfg_idx, cfg_data
//
// One item per cycle while the output is not stalled. The pipeline is one entry stage, 33 + FRAC_BITS
// divider stages (one quotient bit each), then six stages of compare, select, multiply
// and saturate. Synchronous active-low reset clears all valid bits and loads the default
// box corners. A stall at the output freezes the whole pipeline; in_ready follows the
// output register.
module ray_box_slab_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [31:0]                 in_origin_x,
  input  logic signed [31:0]                 in_origin_y,
  input  logic signed [31:0]                 in_origin_z,
  input  logic signed [31:0]                 in_dir_x,
  input  logic signed [31:0]                 in_dir_y,
  input  logic signed [31:0]                 in_dir_z,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_hit,
  output logic [30:0]                        out_distance,
  output logic [1:0]                         out_face_axis,
  output logic                               out_normal_negative,
  output logic signed [31:0]                 out_face_u,
  output logic signed [31:0]                 out_face_v,
  input  logic                               cfg_we,
  input  logic [rbsi_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [31:0]                        cfg_data
);

  localparam int C_W   = rbsi_pkg::COORD_W;
  localparam int DS_W  = rbsi_pkg::DIST_W;
  localparam int NUM_W = C_W + 1;
  localparam int Q_W   = NUM_W + FRAC_BITS;
  localparam int T_W   = Q_W + 1;
  localparam int M_W   = DS_W + C_W;
  localparam int S_W   = M_W + 3;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // box corners
  logic [2:0][C_W-1:0] box_min_r;
  logic [2:0][C_W-1:0] box_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_min_r <= {3{rbsi_pkg::BOX_MIN_RST}};
      box_max_r <= {3{rbsi_pkg::BOX_MAX_RST}};
    end else if (cfg_we) begin
      case (cfg_idx)
        rbsi_pkg::REG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        rbsi_pkg::REG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // entry stage: offsets, magnitudes, signs, slab test for zero directions
  logic [2:0][C_W-1:0]   in_o, in_d;
  logic [2:0][NUM_W-1:0] nmin_nxt, nmax_nxt;
  logic [2:0][C_W-1:0]   dmag_nxt;
  rbsi_pkg::sb_t         sb_nxt;

  assign in_o = {in_origin_z, in_origin_y, in_origin_x};
  assign in_d = {in_dir_z, in_dir_y, in_dir_x};

  always_comb begin
    logic [NUM_W-1:0] dmin, dmax;
    logic             ge_min, le_min, ge_max, le_max;
    sb_nxt       = '0;
    sb_nxt.o     = in_o;
    sb_nxt.d     = in_d;
    for (int i = 0; i < 3; i++) begin
      dmin = {box_min_r[i][C_W-1], box_min_r[i]} - {in_o[i][C_W-1], in_o[i]};
      dmax = {box_max_r[i][C_W-1], box_max_r[i]} - {in_o[i][C_W-1], in_o[i]};
      nmin_nxt[i] = dmin[NUM_W-1] ? (~dmin + 1'b1) : dmin;
      nmax_nxt[i] = dmax[NUM_W-1] ? (~dmax + 1'b1) : dmax;
      dmag_nxt[i] = in_d[i][C_W-1] ? (~in_d[i] + 1'b1) : in_d[i];
      sb_nxt.neg_min[i] = dmin[NUM_W-1] ^ in_d[i][C_W-1];
      sb_nxt.neg_max[i] = dmax[NUM_W-1] ^ in_d[i][C_W-1];
      sb_nxt.dzero[i]   = in_d[i] == '0;
      ge_min = $signed(in_o[i]) >= $signed(box_min_r[i]);
      le_min = $signed(in_o[i]) <= $signed(box_min_r[i]);
      ge_max = $signed(in_o[i]) >= $signed(box_max_r[i]);
      le_max = $signed(in_o[i]) <= $signed(box_max_r[i]);
      if (sb_nxt.dzero[i] && !((ge_min && le_max) || (ge_max && le_min)))
        sb_nxt.miss = 1'b1;
    end
  end

  logic                  s0_valid_r;
  rbsi_pkg::sb_t         s0_sb_r;
  logic [2:0][NUM_W-1:0] s0_nmin_r, s0_nmax_r;
  logic [2:0][C_W-1:0]   s0_dmag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_valid;
    if (en) begin
      s0_sb_r   <= sb_nxt;
      s0_nmin_r <= nmin_nxt;
      s0_nmax_r <= nmax_nxt;
      s0_dmag_r <= dmag_nxt;
    end
  end

  // dividers and matching side delay line
  logic [Q_W-1:0] qmin [3];
  logic [Q_W-1:0] qmax [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rbsi_div #(.NUM_W(NUM_W), .FRAC_W(FRAC_BITS)) u_div_min (
      .clk (clk), .en (en), .num (s0_nmin_r[a]), .den (s0_dmag_r[a]), .quo (qmin[a])
    );
    rbsi_div #(.NUM_W(NUM_W), .FRAC_W(FRAC_BITS)) u_div_max (
      .clk (clk), .en (en), .num (s0_nmax_r[a]), .den (s0_dmag_r[a]), .quo (qmax[a])
    );
  end

  logic [Q_W-1:0] dly_valid_r;
  rbsi_pkg::sb_t  dly_sb_r [Q_W];

  always_ff @(posedge clk) begin
    if (!rst_n) dly_valid_r <= '0;
    else if (en) dly_valid_r <= {dly_valid_r[Q_W-2:0], s0_valid_r};
    if (en) begin
      dly_sb_r[0] <= s0_sb_r;
      for (int j = 1; j < Q_W; j++) dly_sb_r[j] <= dly_sb_r[j-1];
    end
  end

  // stage A: signed slab parameters
  logic                  a_valid_r;
  rbsi_pkg::sb_t         a_sb_r;
  logic signed [T_W-1:0] a_tmin_r [3];
  logic signed [T_W-1:0] a_tmax_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) a_valid_r <= 1'b0;
    else if (en) a_valid_r <= dly_valid_r[Q_W-1];
    if (en) begin
      a_sb_r <= dly_sb_r[Q_W-1];
      for (int i = 0; i < 3; i++) begin
        a_tmin_r[i] <= dly_sb_r[Q_W-1].neg_min[i] ? -$signed({1'b0, qmin[i]})
                                                   : $signed({1'b0, qmin[i]});
        a_tmax_r[i] <= dly_sb_r[Q_W-1].neg_max[i] ? -$signed({1'b0, qmax[i]})
                                                   : $signed({1'b0, qmax[i]});
      end
    end
  end

  // stage B: near and far per axis
  logic                  b_valid_r;
  rbsi_pkg::sb_t         b_sb_r;
  logic signed [T_W-1:0] b_lo_r [3];
  logic signed [T_W-1:0] b_hi_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) b_valid_r <= 1'b0;
    else if (en) b_valid_r <= a_valid_r;
    if (en) begin
      b_sb_r <= a_sb_r;
      for (int i = 0; i < 3; i++) begin
        b_lo_r[i] <= (a_tmin_r[i] < a_tmax_r[i]) ? a_tmin_r[i] : a_tmax_r[i];
        b_hi_r[i] <= (a_tmin_r[i] < a_tmax_r[i]) ? a_tmax_r[i] : a_tmin_r[i];
      end
    end
  end

  // stage C: latest entry, earliest exit, lower axis wins ties
  logic signed [T_W-1:0] tin_nxt, tout_nxt;
  logic [1:0]            kin_nxt, kout_nxt;
  logic                  bnd_nxt;

  always_comb begin
    tin_nxt  = '0;
    tout_nxt = '0;
    kin_nxt  = rbsi_pkg::AXIS_X;
    kout_nxt = rbsi_pkg::AXIS_X;
    bnd_nxt  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (!b_sb_r.dzero[i]) begin
        if (!bnd_nxt || b_lo_r[i] > tin_nxt) begin
          tin_nxt = b_lo_r[i];
          kin_nxt = 2'(i);
        end
        if (!bnd_nxt || b_hi_r[i] < tout_nxt) begin
          tout_nxt = b_hi_r[i];
          kout_nxt = 2'(i);
        end
        bnd_nxt = 1'b1;
      end
    end
  end

  logic                  c_valid_r;
  rbsi_pkg::sb_t         c_sb_r;
  logic signed [T_W-1:0] c_tin_r, c_tout_r;
  logic [1:0]            c_kin_r, c_kout_r;
  logic                  c_bnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_valid_r <= 1'b0;
    else if (en) c_valid_r <= b_valid_r;
    if (en) begin
      c_sb_r   <= b_sb_r;
      c_tin_r  <= tin_nxt;
      c_tout_r <= tout_nxt;
      c_kin_r  <= kin_nxt;
      c_kout_r <= kout_nxt;
      c_bnd_r  <= bnd_nxt;
    end
  end

  // stage D: hit decision, distance, face and the two other axes
  logic                  hit_nxt, nneg_nxt;
  logic signed [T_W-1:0] k_sel;
  logic [1:0]            ax_nxt, ua, va;
  logic [DS_W-1:0]       dist_nxt;
  logic [C_W-1:0]        dax;

  always_comb begin
    hit_nxt = !(c_sb_r.miss || !c_bnd_r || (c_tin_r > c_tout_r) || (c_tout_r <= 0));
    if (c_tin_r > 0) begin
      k_sel  = c_tin_r;
      ax_nxt = c_kin_r;
    end else begin
      k_sel  = c_tout_r;
      ax_nxt = c_kout_r;
    end
    if (k_sel > $signed({{(T_W-DS_W){1'b0}}, {DS_W{1'b1}}}))
      dist_nxt = {DS_W{1'b1}};
    else
      dist_nxt = k_sel[DS_W-1:0];
    case (ax_nxt)
      rbsi_pkg::AXIS_X: begin ua = rbsi_pkg::AXIS_Y; va = rbsi_pkg::AXIS_Z; end
      rbsi_pkg::AXIS_Y: begin ua = rbsi_pkg::AXIS_X; va = rbsi_pkg::AXIS_Z; end
      default:          begin ua = rbsi_pkg::AXIS_X; va = rbsi_pkg::AXIS_Y; end
    endcase
    dax      = c_sb_r.d[ax_nxt];
    nneg_nxt = !dax[C_W-1] && (dax != '0);
  end

  logic            d_valid_r, d_hit_r, d_nneg_r;
  logic [DS_W-1:0] d_dist_r;
  logic [1:0]      d_ax_r;
  logic [C_W-1:0]  d_ou_r, d_du_r, d_cu_r, d_ov_r, d_dv_r, d_cv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_valid_r <= 1'b0;
    else if (en) d_valid_r <= c_valid_r;
    if (en) begin
      d_hit_r  <= hit_nxt;
      d_nneg_r <= nneg_nxt;
      d_dist_r <= dist_nxt;
      d_ax_r   <= ax_nxt;
      d_ou_r   <= c_sb_r.o[ua];
      d_du_r   <= c_sb_r.d[ua];
      d_cu_r   <= box_min_r[ua];
      d_ov_r   <= c_sb_r.o[va];
      d_dv_r   <= c_sb_r.d[va];
      d_cv_r   <= box_min_r[va];
    end
  end

  // stage E: distance times direction magnitude
  logic [C_W-1:0] du_mag, dv_mag;
  assign du_mag = d_du_r[C_W-1] ? (~d_du_r + 1'b1) : d_du_r;
  assign dv_mag = d_dv_r[C_W-1] ? (~d_dv_r + 1'b1) : d_dv_r;

  logic            e_valid_r, e_hit_r, e_nneg_r, e_un_r, e_vn_r;
  logic [DS_W-1:0] e_dist_r;
  logic [1:0]      e_ax_r;
  logic [C_W-1:0]  e_ou_r, e_cu_r, e_ov_r, e_cv_r;
  logic [M_W-1:0]  e_mu_r, e_mv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) e_valid_r <= 1'b0;
    else if (en) e_valid_r <= d_valid_r;
    if (en) begin
      e_hit_r  <= d_hit_r;
      e_nneg_r <= d_nneg_r;
      e_dist_r <= d_dist_r;
      e_ax_r   <= d_ax_r;
      e_un_r   <= d_du_r[C_W-1];
      e_vn_r   <= d_dv_r[C_W-1];
      e_ou_r   <= d_ou_r;
      e_cu_r   <= d_cu_r;
      e_ov_r   <= d_ov_r;
      e_cv_r   <= d_cv_r;
      e_mu_r   <= M_W'(d_dist_r) * M_W'(du_mag);
      e_mv_r   <= M_W'(d_dist_r) * M_W'(dv_mag);
    end
  end

  // stage F: hit point offsets, saturated, into the output register
  function automatic logic [C_W-1:0] hit_coord(input logic [C_W-1:0] o,
                                               input logic [C_W-1:0] c,
                                               input logic [M_W-1:0] m,
                                               input logic           neg);
    logic [M_W-1:0]        step;
    logic signed [S_W-1:0] sv, sum;
    step = m >> FRAC_BITS;
    sv   = $signed({3'b000, step});
    sum  = (neg ? -sv : sv) + S_W'($signed(o)) - S_W'($signed(c));
    if (sum > $signed(S_W'({1'b0, {(C_W-1){1'b1}}})))
      hit_coord = {1'b0, {(C_W-1){1'b1}}};
    else if (sum < -$signed(S_W'({1'b1, {(C_W-1){1'b0}}})))
      hit_coord = {1'b1, {(C_W-1){1'b0}}};
    else
      hit_coord = sum[C_W-1:0];
  endfunction

  logic            out_valid_r, out_hit_r, out_nneg_r;
  logic [DS_W-1:0] out_dist_r;
  logic [1:0]      out_ax_r;
  logic [C_W-1:0]  out_u_r, out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= e_valid_r;
    if (en) begin
      out_hit_r <= e_hit_r;
      if (e_hit_r) begin
        out_dist_r <= e_dist_r;
        out_ax_r   <= e_ax_r;
        out_nneg_r <= e_nneg_r;
        out_u_r    <= hit_coord(e_ou_r, e_cu_r, e_mu_r, e_un_r);
        out_v_r    <= hit_coord(e_ov_r, e_cv_r, e_mv_r, e_vn_r);
      end else begin
        out_dist_r <= {DS_W{1'b1}};
        out_ax_r   <= rbsi_pkg::AXIS_X;
        out_nneg_r <= 1'b0;
        out_u_r    <= '0;
        out_v_r    <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_distance        = out_dist_r;
  assign out_face_axis       = out_ax_r;
  assign out_normal_negative = out_nneg_r;
  assign out_face_u          = out_u_r;
  assign out_face_v          = out_v_r;

`include "ray_box_slab_intersect_assert.svh"

  `RBSI_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s0_valid_r)
  `RBSI_ASSERT_NEXT(a_stall_freezes, !en, $stable(dly_valid_r) && $stable(c_valid_r))
  `RBSI_ASSERT_NOW(a_miss_clean, out_valid_r && !out_hit_r,
                   out_dist_r == {DS_W{1'b1}} && out_u_r == '0 && out_v_r == '0)

endmodule
